FILE: rtl/core/sit_pkg.sv
// types and codes shared by the sorted id table blocks
`timescale 1ns / 1ps

package sit_pkg;

   localparam int ID_W    = 32;
   localparam int FEE_W   = 24;
   localparam int TOTAL_W = 27;
   localparam int STAT_W  = 3;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LIST   = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_DUP      = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_LISTED   = 3'd3,
      STAT_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LIST = 1'b1
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [FEE_W-1:0] fee;
   } record_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/sit_req_if.sv
// request channel: valid, ready and one insert or list beat
`timescale 1ns / 1ps

interface sit_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [31:0]        member_id;
   logic        [23:0]        fee_cents;

   modport source (output valid, output func, output member_id, output fee_cents,
                   input ready);
   modport sink   (input valid, input func, input member_id, input fee_cents,
                   output ready);
endinterface

FILE: rtl/core/sit_rsp_if.sv
// response channel: valid, ready and one result beat
`timescale 1ns / 1ps

interface sit_rsp_if;
   logic                      valid;
   logic                      ready;
   logic        [2:0]         status;
   logic signed [31:0]        entry_id;
   logic        [23:0]        entry_fee;
   logic        [26:0]        running_total;
   logic                      last;

   modport source (output valid, output status, output entry_id, output entry_fee,
                   output running_total, output last, input ready);
   modport sink   (input valid, input status, input entry_id, input entry_fee,
                   input running_total, input last, output ready);
endinterface

FILE: rtl/core/sit_cell.sv
// one table slot: holds a record, compares against the key, shifts or rotates
`timescale 1ns / 1ps

module sit_cell
   import sit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  record_type    key,
   input  record_type    left_rec,
   input  logic          left_valid,
   input  logic          left_lt,
   input  record_type    right_rec,
   input  logic          right_valid,
   input  record_type    head_rec,
   output record_type    rec,
   output logic          valid,
   output logic          lt,
   output logic          match
);

   record_type rec_ff, rec_in;
   logic       valid_ff, valid_in;

   assign lt    = valid_ff && ($signed(rec_ff.id) < $signed(key.id));
   assign match = valid_ff && (rec_ff.id == key.id);
   assign rec   = rec_ff;
   assign valid = valid_ff;

   always_comb begin
      priority if (ctrl.insert && !lt) begin
         // insertion point takes the key, slots above it take their left neighbor
         rec_in   = left_lt ? key : left_rec;
         valid_in = valid_ff | left_valid;
      end else if (ctrl.rotate) begin
         rec_in   = right_valid ? right_rec : head_rec;
         valid_in = valid_ff;
      end else begin
         rec_in   = rec_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rec_ff <= rec_in;
   end

endmodule

FILE: rtl/core/sorted_id_table_core.sv
// sorted id table: chain of record cells with insert and listing control
//
// Request channel req_if carries func, member_id and fee_cents. An insert beat
// (func 0) gives one response beat: inserted, duplicate id or table full; the
// duplicate check wins over the full check. A list beat (func 1) gives one
// response beat per stored record in ascending signed id order with a running
// fee total that saturates, last set on the final beat, or a single table-empty
// beat when nothing is stored.
// An insert is compared against all cells at once and shifts the chain in the
// accepting cycle: its response is registered in the cycle after acceptance, and
// an insert can be accepted every cycle while responses are taken.
// A listing rotates the chain one cell per cycle while responses are taken;
// no request is accepted until the last listed beat is registered.
// The response is held in an output register; when the receiver stalls the
// register holds its beat and the block stops accepting or rotating.
// Reset empties the table and drops any pending response.
`timescale 1ns / 1ps

module sorted_id_table_core
   import sit_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   sit_req_if.sink     req_if,
   sit_rsp_if.source   rsp_if
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [FEE_W-1:0]   rsp_fee_ff, rsp_fee_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   record_type    key;
   record_type    cell_rec   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid;
   logic [TABLE_DEPTH-1:0] cell_lt;
   logic [TABLE_DEPTH-1:0] cell_match;

   logic               slot_free;
   logic               accept;
   logic               dup;
   logic               full;
   logic               list_last;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] sum_sat;

   assign key.id  = req_if.member_id;
   assign key.fee = req_if.fee_cents;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      record_type left_rec, right_rec;
      logic       left_valid, left_lt, right_valid;
      if (i == 0) begin : g_head
         assign left_rec   = key;
         assign left_valid = 1'b1;
         assign left_lt    = 1'b1;
      end else begin : g_body
         assign left_rec   = cell_rec[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_lt    = cell_lt[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_rec   = cell_rec[0];
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_rec   = cell_rec[i+1];
         assign right_valid = cell_valid[i+1];
      end
      sit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key),
         .left_rec    (left_rec),
         .left_valid  (left_valid),
         .left_lt     (left_lt),
         .right_rec   (right_rec),
         .right_valid (right_valid),
         .head_rec    (cell_rec[0]),
         .rec         (cell_rec[i]),
         .valid       (cell_valid[i]),
         .lt          (cell_lt[i]),
         .match       (cell_match[i])
      );
   end

   assign dup       = |cell_match;
   assign full      = cell_valid[TABLE_DEPTH-1];
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign accept    = req_if.valid && req_if.ready;
   assign list_last = (idx_ff + CNT_W'(1)) == count_ff;
   assign sum       = {1'b0, total_ff} + {{(TOTAL_W + 1 - FEE_W){1'b0}}, cell_rec[0].fee};
   assign sum_sat   = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_if.func == FUNC_LIST && count_ff != '0) begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            if (slot_free && list_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_if.ready  = 1'b0;
      ctrl          = '0;
      count_in      = count_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fee_in    = rsp_fee_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = slot_free;
            if (accept) begin
               idx_in   = '0;
               total_in = '0;
               if (req_if.func == FUNC_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = '0;
                  rsp_fee_in   = '0;
                  rsp_total_in = '0;
                  rsp_last_in  = 1'b1;
                  priority if (dup) begin
                     rsp_status_in = STAT_DUP;
                  end else if (full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in = STAT_INSERTED;
                     ctrl.insert   = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
                  rsp_id_in     = '0;
                  rsp_fee_in    = '0;
                  rsp_total_in  = '0;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         ST_LIST: begin
            if (slot_free) begin
               ctrl.rotate   = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_LISTED;
               rsp_id_in     = cell_rec[0].id;
               rsp_fee_in    = cell_rec[0].fee;
               rsp_total_in  = sum_sat;
               rsp_last_in   = list_last;
               total_in      = sum_sat;
               idx_in        = idx_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      total_ff      <= total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_fee_ff    <= rsp_fee_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.entry_id      = rsp_id_ff;
   assign rsp_if.entry_fee     = rsp_fee_ff;
   assign rsp_if.running_total = rsp_total_ff;
   assign rsp_if.last          = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("stored count differs from occupied cells");

   a_cells_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_valid + TABLE_DEPTH'(1)))
      else $error("occupied cells are not a contiguous prefix");

   a_no_accept_in_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIST |-> !req_if.ready)
      else $error("request taken while listing");

   a_full_rejects: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.func == FUNC_INSERT && full |=>
         rsp_status_ff == STAT_DUP || rsp_status_ff == STAT_FULL)
      else $error("insert into a full table was not rejected");

   a_list_ends_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIST && slot_free && list_last |=> rsp_last_ff && state_ff == ST_IDLE)
      else $error("listing ended without last beat");
`endif

endmodule

FILE: sim/sorted_id_table_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_id_table_core with an in-bench table model

module sorted_id_table_core_tb;
   import sit_pkg::*;

   localparam int TABLE_DEPTH = 8;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct {
      status_type             status;
      logic signed [ID_W-1:0] id;
      logic [FEE_W-1:0]       fee;
      logic [TOTAL_W-1:0]     total;
      logic                   last;
   } result_type;

   logic clock;
   logic reset;

   sit_req_if req_if ();
   sit_rsp_if rsp_if ();

   logic signed [ID_W-1:0] table_ids [TABLE_DEPTH];
   logic [FEE_W-1:0]       table_fees [TABLE_DEPTH];
   int                     table_count = 0;
   result_type             expected_beats [$];
   int                     mismatch_count = 0;
   bit                     idle_enable = 1'b1;

   sorted_id_table_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sorted_id_table_core_tb: FAIL");
      $finish;
   end

   function automatic result_type make_result(status_type s, logic signed [ID_W-1:0] id,
                                              logic [FEE_W-1:0] fee,
                                              logic [TOTAL_W-1:0] total, logic last);
      result_type r;
      r.status = s;
      r.id     = id;
      r.fee    = fee;
      r.total  = total;
      r.last   = last;
      return r;
   endfunction

   function automatic status_type insert_record(logic signed [ID_W-1:0] id,
                                                logic [FEE_W-1:0] fee);
      int pos;
      for (int i = 0; i < table_count; i++)
         if (table_ids[i] == id) return STAT_DUP;
      if (table_count >= TABLE_DEPTH) return STAT_FULL;
      pos = 0;
      while (pos < table_count && table_ids[pos] < id) pos++;
      for (int i = table_count; i > pos; i--) begin
         table_ids[i]  = table_ids[i-1];
         table_fees[i] = table_fees[i-1];
      end
      table_ids[pos]  = id;
      table_fees[pos] = fee;
      table_count++;
      return STAT_INSERTED;
   endfunction

   function automatic void predict_beats(func_type f, logic signed [ID_W-1:0] id,
                                         logic [FEE_W-1:0] fee);
      logic [TOTAL_W:0] sum;
      if (f == FUNC_INSERT) begin
         expected_beats.push_back(make_result(insert_record(id, fee), '0, '0, '0, 1'b1));
      end else if (table_count == 0) begin
         expected_beats.push_back(make_result(STAT_EMPTY, '0, '0, '0, 1'b1));
      end else begin
         sum = '0;
         for (int i = 0; i < table_count; i++) begin
            sum = sum + table_fees[i];
            if (sum > TOTAL_MAX) sum = TOTAL_MAX;
            expected_beats.push_back(make_result(STAT_LISTED, table_ids[i], table_fees[i],
                                                 sum[TOTAL_W-1:0],
                                                 (i == table_count - 1)));
         end
      end
   endfunction

   function automatic logic signed [ID_W-1:0] random_id();
      logic signed [ID_W-1:0] v;
      case ($urandom_range(0, 2))
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 40)) - 20;
         default: v = {$urandom_range(0, 1) ? 4'hF : 4'h0, 28'($urandom)};
      endcase
      return v;
   endfunction

   function automatic logic signed [ID_W-1:0] stored_id();
      if (table_count == 0) return random_id();
      return table_ids[$urandom_range(0, table_count - 1)];
   endfunction

   function automatic logic signed [ID_W-1:0] fresh_id();
      logic signed [ID_W-1:0] v;
      bit                     hit;
      do begin
         v   = random_id();
         hit = 1'b0;
         for (int i = 0; i < table_count; i++)
            if (table_ids[i] == v) hit = 1'b1;
      end while (hit);
      return v;
   endfunction

   function automatic logic [FEE_W-1:0] random_fee();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return '0;
         default: return FEE_W'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic send_beat(func_type f, logic signed [ID_W-1:0] id, logic [FEE_W-1:0] fee);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= f;
      req_if.member_id <= id;
      req_if.fee_cents <= fee;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_beats(f, id, fee);
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic random_beat(bit fill);
      int r;
      r = $urandom_range(0, 9);
      if (r < (fill ? 2 : 4))
         send_beat(FUNC_LIST, $urandom, FEE_W'($urandom));
      else if (r < (fill ? 4 : 7))
         send_beat(FUNC_INSERT, stored_id(), random_fee());
      else
         send_beat(FUNC_INSERT, random_id(), random_fee());
   endtask

   // response side: random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_beat
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: status %0d id %0d fee %0d total %0d last %0b",
                                    rsp_if.status, rsp_if.entry_id, rsp_if.entry_fee,
                                    rsp_if.running_total, rsp_if.last));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_if.status !== want.status || rsp_if.entry_id !== want.id ||
                rsp_if.entry_fee !== want.fee || rsp_if.running_total !== want.total ||
                rsp_if.last !== want.last)
               note_mismatch($sformatf({"mismatch: expected status %0d id %0d fee %0d ",
                                        "total %0d last %0b, got status %0d id %0d fee %0d ",
                                        "total %0d last %0b"},
                                       want.status, want.id, want.fee, want.total, want.last,
                                       rsp_if.status, rsp_if.entry_id, rsp_if.entry_fee,
                                       rsp_if.running_total, rsp_if.last));
         end
      end
   end

   task automatic test_empty_listing();
      send_beat(FUNC_LIST, $urandom, FEE_W'($urandom));
      send_beat(FUNC_LIST, '1, '1);
   endtask

   task automatic test_id_extremes();
      send_beat(FUNC_INSERT, 32'sh7FFF_FFFF, '1);
      send_beat(FUNC_INSERT, 32'sh8000_0000, '0);
      send_beat(FUNC_INSERT, '0, 24'd1);
      send_beat(FUNC_INSERT, '0, 24'd123);
      send_beat(FUNC_INSERT, -32'sd1, 24'h80_0000);
      send_beat(FUNC_LIST, '0, '0);
   endtask

   task automatic test_random_fill();
      while (table_count < TABLE_DEPTH) random_beat(1'b1);
      wait_drain();
   endtask

   task automatic test_full_table();
      send_beat(FUNC_INSERT, fresh_id(), '1);
      send_beat(FUNC_INSERT, stored_id(), '1);
      send_beat(FUNC_INSERT, 32'sh8000_0000, 24'h55_5555);
      send_beat(FUNC_INSERT, 32'sh7FFF_FFFF, '0);
      send_beat(FUNC_LIST, '1, '1);
      wait_drain();
   endtask

   task automatic test_random_mix(int count);
      for (int n = 0; n < count; n++) begin
         random_beat(1'b0);
         if (n == count / 2) wait_drain();
      end
   endtask

   task automatic test_no_idle(int count);
      idle_enable = 1'b0;
      for (int n = 0; n < count; n++) random_beat(1'b0);
   endtask

   initial begin
      int drain_wait;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.func      <= FUNC_INSERT;
      req_if.member_id <= '0;
      req_if.fee_cents <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_listing();
      test_id_extremes();
      test_random_fill();
      test_full_table();
      test_random_mix(190);
      test_no_idle(40);

      req_if.valid <= 1'b0;
      drain_wait = 0;
      while (expected_beats.size() != 0 && drain_wait < 100_000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (20) @(posedge clock);
      if (expected_beats.size() != 0)
         note_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
      if (mismatch_count == 0)
         $display("sorted_id_table_core_tb: PASS");
      else
         $display("sorted_id_table_core_tb: FAIL");
      $finish;
   end

endmodule
